/* rtl/core/tcpqd_pkg.sv */
// ----------------------------------------------------------------------------
// tcpqd_pkg
// shared types, widths and codes of the two-class priority queue dispatcher
// ----------------------------------------------------------------------------
package tcpqd_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = 5;
    localparam int TAG_W       = 16;
    localparam int MARK_W      = 5;
    localparam int REG_IDX_W   = 1;
    localparam int CMD_W       = 2;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_LOW_MARK  = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_HIGH_MARK = 1'b1;

    localparam logic [MARK_W-1:0] LOW_MARK_RST  = 5'd8;
    localparam logic [MARK_W-1:0] HIGH_MARK_RST = 5'd15;

    // item modes
    localparam logic MODE_ENQ  = 1'b0;
    localparam logic MODE_DISP = 1'b1;

    // extra server commands
    localparam logic [CMD_W-1:0] SRV_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] SRV_START = 2'd1;
    localparam logic [CMD_W-1:0] SRV_STOP  = 2'd2;

    typedef struct packed {
        logic load_in;
        logic exec;
    } tcpqd_cmd_t;

    typedef struct packed {
        logic out_valid;
    } tcpqd_status_t;

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

/* rtl/core/tcpqd_ctrl.sv */
// ----------------------------------------------------------------------------
// tcpqd_ctrl
// sequencer: captures one item, then runs its queue update once the
// result register is free
// ----------------------------------------------------------------------------
module tcpqd_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     out_ready,
    input  tcpqd_pkg::tcpqd_status_t status,
    output tcpqd_pkg::tcpqd_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_free;

    assign out_free = !status.out_valid || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        in_ready    = 1'b0;
        cmd.load_in = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* rtl/core/tcpqd_dp.sv */
// ----------------------------------------------------------------------------
// tcpqd_dp
// datapath: two circular tag queues, mark registers, hysteresis and the
// result register
// ----------------------------------------------------------------------------
module tcpqd_dp (
    input  logic                                clk,
    input  logic                                rst_n,
    input  tcpqd_pkg::tcpqd_cmd_t               cmd,
    output tcpqd_pkg::tcpqd_status_t            status,
    input  logic                                cfg_we,
    input  logic [tcpqd_pkg::REG_IDX_W-1:0]     cfg_index,
    input  logic [tcpqd_pkg::MARK_W-1:0]        cfg_data,
    input  logic                                mode,
    input  logic                                is_priority,
    input  logic [tcpqd_pkg::TAG_W-1:0]         request_tag,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic                                accepted,
    output logic                                dropped,
    output logic                                popped_valid,
    output logic [tcpqd_pkg::TAG_W-1:0]         popped_tag,
    output logic                                popped_priority,
    output logic [tcpqd_pkg::CMD_W-1:0]         server_command,
    output logic [tcpqd_pkg::CNT_W-1:0]         priority_occupancy,
    output logic [tcpqd_pkg::CNT_W-1:0]         normal_occupancy
);

    // queue storage
    logic [tcpqd_pkg::TAG_W-1:0] p_store [tcpqd_pkg::QUEUE_DEPTH];
    logic [tcpqd_pkg::TAG_W-1:0] n_store [tcpqd_pkg::QUEUE_DEPTH];
    logic [tcpqd_pkg::TAG_W-1:0] p_rd_reg;
    logic [tcpqd_pkg::TAG_W-1:0] n_rd_reg;
    logic                        p_we;
    logic                        n_we;

    // captured item
    logic                        mode_reg;
    logic                        cls_reg;
    logic [tcpqd_pkg::TAG_W-1:0] tag_reg;

    // queue control
    logic [tcpqd_pkg::PTR_W-1:0] p_head_reg, p_head_next;
    logic [tcpqd_pkg::PTR_W-1:0] p_tail_reg, p_tail_next;
    logic [tcpqd_pkg::CNT_W-1:0] p_cnt_reg, p_cnt_next;
    logic [tcpqd_pkg::PTR_W-1:0] n_head_reg, n_head_next;
    logic [tcpqd_pkg::PTR_W-1:0] n_tail_reg, n_tail_next;
    logic [tcpqd_pkg::CNT_W-1:0] n_cnt_reg, n_cnt_next;
    logic                        extra_active_reg, extra_active_next;
    logic                        extra_owner_reg, extra_owner_next;
    logic [tcpqd_pkg::MARK_W-1:0] low_mark_reg;
    logic [tcpqd_pkg::MARK_W-1:0] high_mark_reg;

    // result
    logic                        out_valid_reg, out_valid_next;
    logic                        acc_reg, acc_next;
    logic                        drop_reg, drop_next;
    logic                        pv_reg, pv_next;
    logic [tcpqd_pkg::TAG_W-1:0] ptag_reg, ptag_next;
    logic                        pprio_reg, pprio_next;
    logic [tcpqd_pkg::CMD_W-1:0] scmd_reg, scmd_next;
    logic [tcpqd_pkg::CNT_W-1:0] pocc_reg;
    logic [tcpqd_pkg::CNT_W-1:0] nocc_reg;

    logic                        p_full, p_empty, n_full, n_empty;
    logic [tcpqd_pkg::CNT_W-1:0] owner_cnt;

    assign p_full  = (p_cnt_reg == tcpqd_pkg::CNT_W'(tcpqd_pkg::QUEUE_DEPTH));
    assign n_full  = (n_cnt_reg == tcpqd_pkg::CNT_W'(tcpqd_pkg::QUEUE_DEPTH));
    assign p_empty = (p_cnt_reg == '0);
    assign n_empty = (n_cnt_reg == '0);

    always_comb
    begin
        p_head_next       = p_head_reg;
        p_tail_next       = p_tail_reg;
        p_cnt_next        = p_cnt_reg;
        n_head_next       = n_head_reg;
        n_tail_next       = n_tail_reg;
        n_cnt_next        = n_cnt_reg;
        extra_active_next = extra_active_reg;
        extra_owner_next  = extra_owner_reg;
        p_we              = 1'b0;
        n_we              = 1'b0;
        acc_next          = 1'b0;
        drop_next         = 1'b0;
        pv_next           = 1'b0;
        ptag_next         = '0;
        pprio_next        = 1'b0;
        scmd_next         = tcpqd_pkg::SRV_NONE;
        owner_cnt         = '0;
        if (cmd.exec)
        begin
            if (mode_reg == tcpqd_pkg::MODE_ENQ)
            begin
                if (cls_reg)
                begin
                    if (p_full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        p_we        = 1'b1;
                        p_tail_next = tcpqd_pkg::next_ptr(p_tail_reg);
                        p_cnt_next  = p_cnt_reg + 1'b1;
                        acc_next    = 1'b1;
                    end
                end
                else
                begin
                    if (n_full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        n_we        = 1'b1;
                        n_tail_next = tcpqd_pkg::next_ptr(n_tail_reg);
                        n_cnt_next  = n_cnt_reg + 1'b1;
                        acc_next    = 1'b1;
                    end
                end
            end
            else if (!p_empty || !n_empty)
            begin
                // strict priority pop
                if (!p_empty)
                begin
                    ptag_next   = p_rd_reg;
                    p_head_next = tcpqd_pkg::next_ptr(p_head_reg);
                    p_cnt_next  = p_cnt_reg - 1'b1;
                    pprio_next  = 1'b1;
                end
                else
                begin
                    ptag_next   = n_rd_reg;
                    n_head_next = tcpqd_pkg::next_ptr(n_head_reg);
                    n_cnt_next  = n_cnt_reg - 1'b1;
                end
                pv_next = 1'b1;

                // hysteresis on the post-pop counts
                owner_cnt = extra_owner_reg ? p_cnt_next : n_cnt_next;
                if (extra_active_reg)
                begin
                    if (owner_cnt <= low_mark_reg)
                    begin
                        extra_active_next = 1'b0;
                        scmd_next         = tcpqd_pkg::SRV_STOP;
                    end
                end
                else if (p_cnt_next >= high_mark_reg)
                begin
                    extra_active_next = 1'b1;
                    extra_owner_next  = 1'b1;
                    scmd_next         = tcpqd_pkg::SRV_START;
                end
                else if (n_cnt_next >= high_mark_reg)
                begin
                    extra_active_next = 1'b1;
                    extra_owner_next  = 1'b0;
                    scmd_next         = tcpqd_pkg::SRV_START;
                end
            end
        end
    end

    always_comb
    begin
        if (cmd.exec)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // tag memories, registered read at the heads
    always_ff @(posedge clk)
    begin
        if (p_we)
        begin
            p_store[p_tail_reg] <= tag_reg;
        end
        p_rd_reg <= p_store[p_head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (n_we)
        begin
            n_store[n_tail_reg] <= tag_reg;
        end
        n_rd_reg <= n_store[n_head_reg];
    end

    // item and result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg <= mode;
            cls_reg  <= is_priority;
            tag_reg  <= request_tag;
        end
        if (cmd.exec)
        begin
            acc_reg   <= acc_next;
            drop_reg  <= drop_next;
            pv_reg    <= pv_next;
            ptag_reg  <= ptag_next;
            pprio_reg <= pprio_next;
            scmd_reg  <= scmd_next;
            pocc_reg  <= p_cnt_next;
            nocc_reg  <= n_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_head_reg       <= '0;
            p_tail_reg       <= '0;
            p_cnt_reg        <= '0;
            n_head_reg       <= '0;
            n_tail_reg       <= '0;
            n_cnt_reg        <= '0;
            extra_active_reg <= 1'b0;
            extra_owner_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            low_mark_reg     <= tcpqd_pkg::LOW_MARK_RST;
            high_mark_reg    <= tcpqd_pkg::HIGH_MARK_RST;
        end
        else
        begin
            p_head_reg       <= p_head_next;
            p_tail_reg       <= p_tail_next;
            p_cnt_reg        <= p_cnt_next;
            n_head_reg       <= n_head_next;
            n_tail_reg       <= n_tail_next;
            n_cnt_reg        <= n_cnt_next;
            extra_active_reg <= extra_active_next;
            extra_owner_reg  <= extra_owner_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    tcpqd_pkg::REG_LOW_MARK:  low_mark_reg  <= cfg_data;
                    tcpqd_pkg::REG_HIGH_MARK: high_mark_reg <= cfg_data;
                    default:                  low_mark_reg  <= low_mark_reg;
                endcase
            end
        end
    end

    assign status.out_valid   = out_valid_reg;
    assign out_valid          = out_valid_reg;
    assign accepted           = acc_reg;
    assign dropped            = drop_reg;
    assign popped_valid       = pv_reg;
    assign popped_tag         = ptag_reg;
    assign popped_priority    = pprio_reg;
    assign server_command     = scmd_reg;
    assign priority_occupancy = pocc_reg;
    assign normal_occupancy   = nocc_reg;

endmodule

/* rtl/core/two_class_priority_queue_dispatcher.sv */
// ----------------------------------------------------------------------------
// two_class_priority_queue_dispatcher
// strict-priority dual tag queue with a hysteresis-controlled extra server
// ----------------------------------------------------------------------------
// Each input beat either enqueues a tag (mode 0) into the priority or normal
// queue, 16 entries each, or dispatches (mode 1) the oldest tag of the
// priority queue, falling back to the normal queue; every beat yields exactly
// one result beat. An item is first captured while the queue-head memories
// present their registered read data; once the result register is free, the
// pointers, counts and hysteresis state are updated and the result register
// is loaded. The next item is taken while a finished result still waits on
// out_ready, but the block holds only one item in flight at a time.
// After each successful pop, with no extra server running, a queue at or
// above high_mark (priority checked first) starts one and becomes its owner;
// with one running, the owner queue at or below low_mark stops it. The user
// is to write the marks (index 0 low_mark, index 1 high_mark) only while the
// block is idle; the block does not check it. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
module two_class_priority_queue_dispatcher (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration writes
    input  logic                            cfg_we,
    input  logic [tcpqd_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [tcpqd_pkg::MARK_W-1:0]    cfg_data,
    // item channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            mode,
    input  logic                            is_priority,
    input  logic [tcpqd_pkg::TAG_W-1:0]     request_tag,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            accepted,
    output logic                            dropped,
    output logic                            popped_valid,
    output logic [tcpqd_pkg::TAG_W-1:0]     popped_tag,
    output logic                            popped_priority,
    output logic [tcpqd_pkg::CMD_W-1:0]     server_command,
    output logic [tcpqd_pkg::CNT_W-1:0]     priority_occupancy,
    output logic [tcpqd_pkg::CNT_W-1:0]     normal_occupancy
);

    // command and status between sequencer and datapath
    tcpqd_pkg::tcpqd_cmd_t    ctrl_cmd;
    tcpqd_pkg::tcpqd_status_t dp_status;

    // sequencer: idle -> capture beat -> execute when result slot frees
    tcpqd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (dp_status),
        .cmd       (ctrl_cmd)
    );

    // queues, marks, hysteresis and result register
    tcpqd_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (ctrl_cmd),
        .status             (dp_status),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mode               (mode),
        .is_priority        (is_priority),
        .request_tag        (request_tag),
        .out_ready          (out_ready),
        .out_valid          (out_valid),
        .accepted           (accepted),
        .dropped            (dropped),
        .popped_valid       (popped_valid),
        .popped_tag         (popped_tag),
        .popped_priority    (popped_priority),
        .server_command     (server_command),
        .priority_occupancy (priority_occupancy),
        .normal_occupancy   (normal_occupancy)
    );

`ifndef SYNTH
    // one item in flight: an accepted beat closes the input until it executes
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken while an item is still in flight");

    // an enqueue result and a dispatch result never mix
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && popped_valid) |-> (!accepted && !dropped))
        else $error("dispatch result carries enqueue flags");

    // server start or stop only follows a successful pop
    a_cmd_needs_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && server_command != tcpqd_pkg::SRV_NONE) |-> popped_valid)
        else $error("server command without a pop");

    // occupancies never pass the queue depth
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (priority_occupancy <= tcpqd_pkg::CNT_W'(tcpqd_pkg::QUEUE_DEPTH)
             && normal_occupancy <= tcpqd_pkg::CNT_W'(tcpqd_pkg::QUEUE_DEPTH)))
        else $error("queue occupancy above depth");
`endif

endmodule

/* tb/tb_two_class_priority_queue_dispatcher.sv */
// ----------------------------------------------------------------------------
// tb_two_class_priority_queue_dispatcher
// self-checking bench for the two-class priority queue dispatcher
// ----------------------------------------------------------------------------
// A short table of directed beats covers the reset marks, the empty dispatch,
// extreme tags, a full priority queue with a drop, and a server start. Some
// rows carry a typed-in result; the others are checked against a cycle-free
// model of the two queues and the hysteresis rule. Random phases follow, one
// per pair of marks (extremes included). They are built from fill bursts,
// drain bursts and noise, so the queues reach full and the extra server is
// started and stopped. Both channels stall at random, except in one phase
// that runs with no stalls at all.
// ----------------------------------------------------------------------------
module tb_two_class_priority_queue_dispatcher;

    timeunit 1ns;
    timeprecision 1ps;

    import tcpqd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int N_DIR        = 22;
    localparam int PHASE_ITEMS  = 130;
    localparam int STALL_PCT    = 29;
    localparam int MAX_PRINTS   = 100;

    typedef struct packed {
        logic             mode;
        logic             is_priority;
        logic [TAG_W-1:0] tag;
    } disp_item_t;

    typedef struct packed {
        logic             accepted;
        logic             dropped;
        logic             popped_valid;
        logic [TAG_W-1:0] popped_tag;
        logic             popped_priority;
        logic [CMD_W-1:0] server_command;
        logic [CNT_W-1:0] priority_occupancy;
        logic [CNT_W-1:0] normal_occupancy;
    } disp_result_t;

    // a result typed into the table, or none (then the model decides)
    typedef struct packed {
        logic         pinned;
        disp_result_t want;
    } result_note_t;

    typedef struct packed {
        disp_item_t   item;
        result_note_t note;
    } dir_row_t;

    // ------------------------------------------------------------------------
    // block ports; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 cfg_we      = 1'b0;
    logic [REG_IDX_W-1:0] cfg_index   = REG_LOW_MARK;
    logic [MARK_W-1:0]    cfg_data    = '0;
    logic                 in_valid    = 1'b0;
    logic                 in_ready;
    logic                 mode        = MODE_ENQ;
    logic                 is_priority = 1'b0;
    logic [TAG_W-1:0]     request_tag = '0;
    logic                 out_valid;
    logic                 out_ready   = 1'b0;
    logic                 accepted;
    logic                 dropped;
    logic                 popped_valid;
    logic [TAG_W-1:0]     popped_tag;
    logic                 popped_priority;
    logic [CMD_W-1:0]     server_command;
    logic [CNT_W-1:0]     priority_occupancy;
    logic [CNT_W-1:0]     normal_occupancy;

    two_class_priority_queue_dispatcher u_top (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .mode               (mode),
        .is_priority        (is_priority),
        .request_tag        (request_tag),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .accepted           (accepted),
        .dropped            (dropped),
        .popped_valid       (popped_valid),
        .popped_tag         (popped_tag),
        .popped_priority    (popped_priority),
        .server_command     (server_command),
        .priority_occupancy (priority_occupancy),
        .normal_occupancy   (normal_occupancy)
    );

    // ------------------------------------------------------------------------
    // model of the dispatcher: its own queues, counts, server state and marks
    // ------------------------------------------------------------------------
    logic [TAG_W-1:0]  prio_mem [QUEUE_DEPTH];
    logic [TAG_W-1:0]  norm_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  prio_rd = '0, prio_wr = '0;
    logic [PTR_W-1:0]  norm_rd = '0, norm_wr = '0;
    logic [CNT_W-1:0]  prio_cnt = '0, norm_cnt = '0;
    logic              server_on = 1'b0;
    logic              server_owner_prio = 1'b0;
    logic [MARK_W-1:0] mark_lo = LOW_MARK_RST;
    logic [MARK_W-1:0] mark_hi = HIGH_MARK_RST;

    disp_result_t pending_results [$];
    result_note_t pinned_notes [$];
    int           err_count   = 0;
    int           cycle_count = 0;
    bit           steady      = 1'b0;  // no stalls on either side while set

    function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
        return PTR_W'((int'(p) + 1) % QUEUE_DEPTH);
    endfunction

    // one beat in, one result out; updates the model state
    function automatic disp_result_t predict_dispatch(input disp_item_t it);
        disp_result_t     r;
        logic [CNT_W-1:0] owner_cnt;
        r = '0;
        if (it.mode == MODE_ENQ)
        begin
            if (it.is_priority)
            begin
                if (prio_cnt >= CNT_W'(QUEUE_DEPTH))
                    r.dropped = 1'b1;
                else
                begin
                    prio_mem[prio_wr] = it.tag;
                    prio_wr           = wrap_inc(prio_wr);
                    prio_cnt          = prio_cnt + 1'b1;
                    r.accepted        = 1'b1;
                end
            end
            else
            begin
                if (norm_cnt >= CNT_W'(QUEUE_DEPTH))
                    r.dropped = 1'b1;
                else
                begin
                    norm_mem[norm_wr] = it.tag;
                    norm_wr           = wrap_inc(norm_wr);
                    norm_cnt          = norm_cnt + 1'b1;
                    r.accepted        = 1'b1;
                end
            end
        end
        else if (prio_cnt != 0 || norm_cnt != 0)
        begin
            // strict priority: the normal queue only when priority is empty
            if (prio_cnt != 0)
            begin
                r.popped_tag      = prio_mem[prio_rd];
                prio_rd           = wrap_inc(prio_rd);
                prio_cnt          = prio_cnt - 1'b1;
                r.popped_priority = 1'b1;
            end
            else
            begin
                r.popped_tag = norm_mem[norm_rd];
                norm_rd      = wrap_inc(norm_rd);
                norm_cnt     = norm_cnt - 1'b1;
            end
            r.popped_valid = 1'b1;
            // hysteresis, only after a real pop
            if (server_on)
            begin
                owner_cnt = server_owner_prio ? prio_cnt : norm_cnt;
                if (owner_cnt <= mark_lo)
                begin
                    server_on        = 1'b0;
                    r.server_command = SRV_STOP;
                end
            end
            else if (prio_cnt >= mark_hi)
            begin
                server_on         = 1'b1;
                server_owner_prio = 1'b1;
                r.server_command  = SRV_START;
            end
            else if (norm_cnt >= mark_hi)
            begin
                server_on         = 1'b1;
                server_owner_prio = 1'b0;
                r.server_command  = SRV_START;
            end
        end
        r.priority_occupancy = prio_cnt;
        r.normal_occupancy   = norm_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [TAG_W-1:0] got,
                                   input logic [TAG_W-1:0] want);
        if (err_count < MAX_PRINTS)
            $display("mismatch %s: got %h want %h (cycle %0d)", what, got, want,
                     cycle_count);
        err_count++;
    endtask

    task automatic check_result(input disp_result_t want);
        if (accepted !== want.accepted)
            report_mismatch("accepted", TAG_W'(accepted), TAG_W'(want.accepted));
        if (dropped !== want.dropped)
            report_mismatch("dropped", TAG_W'(dropped), TAG_W'(want.dropped));
        if (popped_valid !== want.popped_valid)
            report_mismatch("popped_valid", TAG_W'(popped_valid),
                            TAG_W'(want.popped_valid));
        if (popped_tag !== want.popped_tag)
            report_mismatch("popped_tag", popped_tag, want.popped_tag);
        if (popped_priority !== want.popped_priority)
            report_mismatch("popped_priority", TAG_W'(popped_priority),
                            TAG_W'(want.popped_priority));
        if (server_command !== want.server_command)
            report_mismatch("server_command", TAG_W'(server_command),
                            TAG_W'(want.server_command));
        if (priority_occupancy !== want.priority_occupancy)
            report_mismatch("priority_occupancy", TAG_W'(priority_occupancy),
                            TAG_W'(want.priority_occupancy));
        if (normal_occupancy !== want.normal_occupancy)
            report_mismatch("normal_occupancy", TAG_W'(normal_occupancy),
                            TAG_W'(want.normal_occupancy));
    endtask

    // all sampling at the rising edge sees the values from before the edge
    always @(posedge clk)
    begin : monitor
        disp_item_t   seen;
        disp_result_t predicted;
        result_note_t note;
        if (rst_n)
        begin
            // mark writes land in the model at the same edge as in the block
            if (cfg_we)
            begin
                if (cfg_index == REG_LOW_MARK)
                    mark_lo = cfg_data;
                else if (cfg_index == REG_HIGH_MARK)
                    mark_hi = cfg_data;
            end
            // accepted item beat: predict, or take the typed-in result
            if (in_valid && in_ready)
            begin
                seen.mode        = mode;
                seen.is_priority = is_priority;
                seen.tag         = request_tag;
                predicted        = predict_dispatch(seen);
                note             = pinned_notes.pop_front();
                pending_results.push_back(note.pinned ? note.want : predicted);
            end
            // accepted result beat: compare with the oldest expectation
            if (out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result beat with nothing expected",
                                    TAG_W'(out_valid), '0);
                else
                    check_result(pending_results.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // clock, cycle limit, result-side stalls
    // ------------------------------------------------------------------------
    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // ------------------------------------------------------------------------
    // item-side driving
    // ------------------------------------------------------------------------
    // raise a beat after an optional random gap and hold it until accepted;
    // valid stays high on return so back-to-back beats need no second drive
    task automatic send_item(input disp_item_t it, input result_note_t note);
        while (!steady && $urandom_range(0, 99) < STALL_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= it.mode;
        is_priority <= it.is_priority;
        request_tag <= it.tag;
        pinned_notes.push_back(note);
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // drop valid, then wait for every expected result and a short tail
    task automatic drain_block();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both marks, one write per cycle
    task automatic write_marks(input logic [MARK_W-1:0] lo, input logic [MARK_W-1:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= REG_LOW_MARK;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= REG_HIGH_MARK;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // random beats in bursts: fills that push one class toward full, drains
    // that walk the occupancy back down past the low mark, and plain noise
    task automatic run_random(input int n_items);
        int           sent;
        int           kind;
        int           len;
        bit           bias;
        disp_item_t   it;
        result_note_t none;
        none = '0;
        sent = 0;
        while (sent < n_items)
        begin
            kind = $urandom_range(0, 99);
            bias = 1'($urandom_range(0, 1));
            len  = (kind < 70) ? $urandom_range(8, 22) : $urandom_range(3, 10);
            for (int k = 0; k < len; k++)
            begin
                it.tag         = TAG_W'($urandom);
                it.is_priority = 1'($urandom_range(0, 1));
                if (kind < 35)
                begin
                    it.mode = ($urandom_range(0, 99) < 90) ? MODE_ENQ : MODE_DISP;
                    if ($urandom_range(0, 99) < 75)
                        it.is_priority = bias;
                end
                else if (kind < 70)
                    it.mode = ($urandom_range(0, 99) < 90) ? MODE_DISP : MODE_ENQ;
                else
                    it.mode = 1'($urandom_range(0, 1));
                send_item(it, none);
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        dir_row_t          dir_rows [N_DIR];
        logic [MARK_W-1:0] lo_list [7];
        logic [MARK_W-1:0] hi_list [7];

        // directed table, under the reset marks (low 8, high 15)
        for (int i = 0; i < N_DIR; i++)
            dir_rows[i] = '0;
        // dispatch on an empty block: nothing popped, no hysteresis
        dir_rows[0].item.mode   = MODE_DISP;
        dir_rows[0].note.pinned = 1'b1;
        // largest tag into the normal queue
        dir_rows[1].item                        = '{MODE_ENQ, 1'b0, 16'hffff};
        dir_rows[1].note.pinned                 = 1'b1;
        dir_rows[1].note.want.accepted          = 1'b1;
        dir_rows[1].note.want.normal_occupancy  = 5'd1;
        // smallest tag into the priority queue
        dir_rows[2].item                          = '{MODE_ENQ, 1'b1, 16'h0000};
        dir_rows[2].note.pinned                   = 1'b1;
        dir_rows[2].note.want.accepted            = 1'b1;
        dir_rows[2].note.want.priority_occupancy  = 5'd1;
        dir_rows[2].note.want.normal_occupancy    = 5'd1;
        // fill the priority queue to its depth, walking-one tags
        for (int i = 3; i < 18; i++)
            dir_rows[i].item = '{MODE_ENQ, 1'b1, TAG_W'(1) << (i - 3)};
        // full priority queue: the beat is dropped
        dir_rows[18].item                         = '{MODE_ENQ, 1'b1, 16'h1234};
        dir_rows[18].note.pinned                  = 1'b1;
        dir_rows[18].note.want.dropped            = 1'b1;
        dir_rows[18].note.want.priority_occupancy = 5'd16;
        dir_rows[18].note.want.normal_occupancy   = 5'd1;
        // first pop leaves 15 at the high mark: server start, priority owner
        dir_rows[19].item = '{MODE_DISP, 1'b0, 16'h0000};
        // class and tag on a dispatch are ignored
        dir_rows[20].item = '{MODE_DISP, 1'b1, 16'hffff};
        dir_rows[21].item = '{MODE_ENQ, 1'b0, 16'ha5a5};

        // mark settings of the random phases, extremes first
        lo_list = '{5'd0, 5'd16, 5'd0, 5'd16, 5'd5, 5'd0, 5'd8};
        hi_list = '{5'd16, 5'd0, 5'd0, 5'd16, 5'd12, 5'd0, 5'd15};
        lo_list[5] = MARK_W'($urandom_range(0, 16));
        hi_list[5] = MARK_W'($urandom_range(0, 16));

        // reset held, then released at an edge
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIR; i++)
            send_item(dir_rows[i].item, dir_rows[i].note);
        drain_block();

        for (int ph = 0; ph < 7; ph++)
        begin
            write_marks(lo_list[ph], hi_list[ph]);
            steady = (ph == 2);  // one phase with no stalls on either side
            run_random(PHASE_ITEMS);
            drain_block();
            steady = 1'b0;
        end

        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/tcpqd_pkg.sv
rtl/core/tcpqd_ctrl.sv
rtl/core/tcpqd_dp.sv
rtl/core/two_class_priority_queue_dispatcher.sv
tb/tb_two_class_priority_queue_dispatcher.sv
